>>> rtl/ubdc_pkg.sv
// Package for the UART baud divisor calculator.
// Holds widths, reset values, register codes and the types shared among the modules.
// No dependencies.
package ubdc_pkg;

  localparam int CLOCK_BITS    = 28;
  localparam int MANTISSA_BITS = 12;
  localparam int BAUD_BITS     = 24;
  localparam int FRAC_BITS     = 4;
  localparam int WORD_BITS     = 16;
  localparam int QUO_BITS      = MANTISSA_BITS + FRAC_BITS;
  localparam int NUM_BITS      = CLOCK_BITS + 2;
  localparam int DIV_BITS      = BAUD_BITS + 1;
  localparam int HI_BITS       = NUM_BITS - QUO_BITS;
  localparam int SRC_BITS      = 2;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CLOCK_BITS-1:0] OSC_RESET_HZ  = CLOCK_BITS'(16000000);
  localparam logic [CLOCK_BITS-1:0] SLOW_RESET_HZ = CLOCK_BITS'(42000000);
  localparam logic [CLOCK_BITS-1:0] FAST_RESET_HZ = CLOCK_BITS'(84000000);

  localparam logic [MANTISSA_BITS-1:0] MANT_MAX = {MANTISSA_BITS{1'b1}};
  localparam logic [FRAC_BITS-1:0] FRAC_MAX_BY16 = {FRAC_BITS{1'b1}};
  localparam logic [FRAC_BITS-1:0] FRAC_MAX_BY8  = {1'b0, {(FRAC_BITS-1){1'b1}}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CLOCK_SOURCE = 2'd0,
    CFG_OSC_CLOCK    = 2'd1,
    CFG_SLOW_CLOCK   = 2'd2,
    CFG_FAST_CLOCK   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SRC_BITS-1:0]   clock_source_code;
    logic [CLOCK_BITS-1:0] oscillator_clock_hz;
    logic [CLOCK_BITS-1:0] slow_bus_clock_hz;
    logic [CLOCK_BITS-1:0] fast_bus_clock_hz;
  } clk_cfg_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] rem;
    logic [QUO_BITS-1:0] nq;
    logic [DIV_BITS-1:0] div;
    logic                ovf;
    logic                by8;
  } div_lane_t;

endpackage

>>> rtl/ubdc_in_if.sv
// Request channel of the UART baud divisor calculator.
// Depends on ubdc_pkg.
interface ubdc_in_if;
  import ubdc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BAUD_BITS-1:0] baud_rate;
  logic                 on_fast_bus;
  logic                 oversample_by_8;

  modport source (output valid, baud_rate, on_fast_bus, oversample_by_8, input ready);
  modport sink   (input valid, baud_rate, on_fast_bus, oversample_by_8, output ready);
endinterface

>>> rtl/ubdc_out_if.sv
// Result channel of the UART baud divisor calculator.
// Depends on ubdc_pkg.
interface ubdc_out_if;
  import ubdc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [WORD_BITS-1:0]     divisor_word;
  logic [MANTISSA_BITS-1:0] mantissa;
  logic [FRAC_BITS-1:0]     fraction;
  logic                     out_of_range;

  modport source (output valid, divisor_word, mantissa, fraction, out_of_range, input ready);
  modport sink   (input valid, divisor_word, mantissa, fraction, out_of_range, output ready);
endinterface

>>> rtl/ubdc_head.sv
// Front of the divider chain: kernel clock select, numerator and divisor set-up,
// and the overflow test on the top numerator bits. Depends on ubdc_pkg.
module ubdc_head (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  ubdc_pkg::clk_cfg_t             cfg_i,
  input  logic [ubdc_pkg::BAUD_BITS-1:0] baud_rate_i,
  input  logic                           on_fast_bus_i,
  input  logic                           oversample_by_8_i,
  output logic                           valid_o,
  output ubdc_pkg::div_lane_t            lane_o
);
  import ubdc_pkg::*;

  logic [CLOCK_BITS-1:0] clk_sel;
  logic [NUM_BITS-1:0]   num_d, num_q;
  logic [DIV_BITS-1:0]   div_d, div_q;
  logic                  by8_q;
  logic                  s1_valid_q;
  logic [HI_BITS-1:0]    num_hi;
  logic                  ovf;
  div_lane_t             lane_d, lane_q;
  logic                  s2_valid_q;

  always_comb begin
    if (cfg_i.clock_source_code != '0) begin
      clk_sel = on_fast_bus_i ? cfg_i.fast_bus_clock_hz : cfg_i.slow_bus_clock_hz;
    end else begin
      clk_sel = cfg_i.oscillator_clock_hz;
    end
    num_d = NUM_BITS'({clk_sel, 1'b0}) + NUM_BITS'(baud_rate_i);
    div_d = {baud_rate_i, 1'b0};
  end

  // The quotient needs more than QUO_BITS bits exactly when the top numerator
  // bits already reach the divisor.
  always_comb begin
    num_hi       = num_q[NUM_BITS-1:QUO_BITS];
    ovf          = DIV_BITS'(num_hi) >= div_q;
    lane_d.rem   = ovf ? '0 : DIV_BITS'(num_hi);
    lane_d.nq    = num_q[QUO_BITS-1:0];
    lane_d.div   = div_q;
    lane_d.ovf   = ovf;
    lane_d.by8   = by8_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      div_q  <= div_d;
      by8_q  <= oversample_by_8_i;
      lane_q <= lane_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign lane_o  = lane_q;

endmodule

>>> rtl/ubdc_cell.sv
// One restoring division step: shifts in one numerator bit and yields one quotient bit.
// Depends on ubdc_pkg.
module ubdc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  ubdc_pkg::div_lane_t lane_i,
  output logic                valid_o,
  output ubdc_pkg::div_lane_t lane_o
);
  import ubdc_pkg::*;

  logic [DIV_BITS:0] trial;
  logic [DIV_BITS:0] diff;
  logic              ge;
  div_lane_t         lane_d, lane_q;
  logic              valid_q;

  always_comb begin
    trial      = {lane_i.rem, lane_i.nq[QUO_BITS-1]};
    diff       = trial - {1'b0, lane_i.div};
    ge         = trial >= {1'b0, lane_i.div};
    lane_d     = lane_i;
    lane_d.rem = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
    lane_d.nq  = {lane_i.nq[QUO_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

>>> rtl/ubdc_tail.sv
// End of the divider chain: splits the quotient into mantissa and fraction,
// saturates on overflow and holds the output register. Depends on ubdc_pkg.
module ubdc_tail (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  ubdc_pkg::div_lane_t                lane_i,
  output logic                               valid_o,
  output logic [ubdc_pkg::WORD_BITS-1:0]     divisor_word_o,
  output logic [ubdc_pkg::MANTISSA_BITS-1:0] mantissa_o,
  output logic [ubdc_pkg::FRAC_BITS-1:0]     fraction_o,
  output logic                               out_of_range_o
);
  import ubdc_pkg::*;

  logic [QUO_BITS-1:0]      quo;
  logic [MANTISSA_BITS-1:0] mant_raw, mant_d, mant_q;
  logic [FRAC_BITS-1:0]     frac_raw, frac_d, frac_q;
  logic                     ovf_d, ovf_q;
  logic                     valid_q;

  always_comb begin
    quo      = lane_i.nq;
    mant_raw = lane_i.by8 ? quo[QUO_BITS-2:FRAC_BITS-1] : quo[QUO_BITS-1:FRAC_BITS];
    frac_raw = lane_i.by8 ? {1'b0, quo[FRAC_BITS-2:0]} : quo[FRAC_BITS-1:0];
    ovf_d    = lane_i.ovf | (lane_i.by8 & quo[QUO_BITS-1]);
    if (ovf_d) begin
      mant_d = MANT_MAX;
      frac_d = lane_i.by8 ? FRAC_MAX_BY8 : FRAC_MAX_BY16;
    end else begin
      mant_d = mant_raw;
      frac_d = frac_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mant_q <= mant_d;
      frac_q <= frac_d;
      ovf_q  <= ovf_d;
    end
  end

  assign valid_o        = valid_q;
  assign mantissa_o     = mant_q;
  assign fraction_o     = frac_q;
  assign out_of_range_o = ovf_q;
  assign divisor_word_o = WORD_BITS'({mant_q, frac_q});

endmodule

>>> rtl/uart_baud_divisor_calc.sv
// UART baud divisor calculator, top level: configuration registers and the divider chain.
// From an accepted request beat to its result beat, a request passes through two set-up
// stages, sixteen division cells (one quotient bit each) and the output register.
// Throughput is one beat per cycle; the whole chain advances whenever the output register
// is empty or being taken. Reset clears every valid bit and loads the clock registers
// with their default frequencies. Depends on ubdc_pkg, the channel interfaces and cells.
module uart_baud_divisor_calc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ubdc_in_if.sink                           in_i,
  ubdc_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [ubdc_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ubdc_pkg::CLOCK_BITS-1:0]   cfg_data_i
);
  import ubdc_pkg::*;

  clk_cfg_t  cfg_q;
  logic      en;
  div_lane_t lane [QUO_BITS+1];
  logic [QUO_BITS:0] lane_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_source_code   <= '0;
      cfg_q.oscillator_clock_hz <= OSC_RESET_HZ;
      cfg_q.slow_bus_clock_hz   <= SLOW_RESET_HZ;
      cfg_q.fast_bus_clock_hz   <= FAST_RESET_HZ;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLOCK_SOURCE: cfg_q.clock_source_code   <= cfg_data_i[SRC_BITS-1:0];
        CFG_OSC_CLOCK:    cfg_q.oscillator_clock_hz <= cfg_data_i;
        CFG_SLOW_CLOCK:   cfg_q.slow_bus_clock_hz   <= cfg_data_i;
        CFG_FAST_CLOCK:   cfg_q.fast_bus_clock_hz   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  ubdc_head u_head (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .valid_i           (in_i.valid),
    .cfg_i             (cfg_q),
    .baud_rate_i       (in_i.baud_rate),
    .on_fast_bus_i     (in_i.on_fast_bus),
    .oversample_by_8_i (in_i.oversample_by_8),
    .valid_o           (lane_valid[0]),
    .lane_o            (lane[0])
  );

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_cell
    ubdc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (lane_valid[g]),
      .lane_i  (lane[g]),
      .valid_o (lane_valid[g+1]),
      .lane_o  (lane[g+1])
    );
  end

  ubdc_tail u_tail (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (lane_valid[QUO_BITS]),
    .lane_i         (lane[QUO_BITS]),
    .valid_o        (out_o.valid),
    .divisor_word_o (out_o.divisor_word),
    .mantissa_o     (out_o.mantissa),
    .fraction_o     (out_o.fraction),
    .out_of_range_o (out_o.out_of_range)
  );

  a_last_cell_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_valid[QUO_BITS] && en |=> out_o.valid)
    else $error("Beat leaving the last cell did not reach the output register.");

  a_stall_freezes_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(lane_valid))
    else $error("Divider chain moved while the output was stalled.");

  a_saturated_mantissa: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.out_of_range |-> out_o.mantissa == MANT_MAX)
    else $error("Out-of-range result without a saturated mantissa.");

endmodule

>>> tb/ubdc_divisor_checker.sv
// Checker for the UART baud divisor calculator: follows configuration writes and
// request beats, predicts each divisor and compares it with the result beats.
// Depends on ubdc_pkg and the request and result channel interfaces.
module ubdc_divisor_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ubdc_in_if                                req_i,
  ubdc_out_if                               res_i,
  input  logic                              cfg_we_i,
  input  logic [ubdc_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ubdc_pkg::CLOCK_BITS-1:0]   cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import ubdc_pkg::*;

  typedef struct packed {
    logic [WORD_BITS-1:0]     divisor_word;
    logic [MANTISSA_BITS-1:0] mantissa;
    logic [FRAC_BITS-1:0]     fraction;
    logic                     out_of_range;
  } divisor_t;

  logic [SRC_BITS-1:0]   src_code;
  logic [CLOCK_BITS-1:0] osc_hz;
  logic [CLOCK_BITS-1:0] slow_hz;
  logic [CLOCK_BITS-1:0] fast_hz;
  divisor_t              divisor_q[$];
  divisor_t              want;
  int                    fails;

  function automatic divisor_t predict_divisor(logic [BAUD_BITS-1:0] baud, logic fast,
                                               logic by8);
    divisor_t    r;
    logic [63:0] kernel_hz;
    logic [63:0] quo;
    logic [63:0] mant;
    logic [63:0] frac;
    logic [63:0] frac_top;
    int          shift;
    shift = by8 ? 3 : 4;
    frac_top = (64'd1 << shift) - 64'd1;
    if (src_code != '0) begin
      kernel_hz = fast ? 64'(fast_hz) : 64'(slow_hz);
    end else begin
      kernel_hz = 64'(osc_hz);
    end
    r.out_of_range = 1'b0;
    if (baud == '0) begin
      mant = 64'(MANT_MAX);
      frac = frac_top;
      r.out_of_range = 1'b1;
    end else begin
      // Rounds the clock-to-baud ratio to the nearest unit, halves going up.
      quo = (64'd2 * kernel_hz + 64'(baud)) / (64'd2 * 64'(baud));
      mant = quo >> shift;
      frac = quo & frac_top;
      if (mant > 64'(MANT_MAX)) begin
        mant = 64'(MANT_MAX);
        frac = frac_top;
        r.out_of_range = 1'b1;
      end
    end
    r.mantissa = mant[MANTISSA_BITS-1:0];
    r.fraction = frac[FRAC_BITS-1:0];
    r.divisor_word = WORD_BITS'((mant << 4) | frac);
    return r;
  endfunction

  function automatic int check_field(string name, logic [WORD_BITS-1:0] exp_val,
                                     logic [WORD_BITS-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_code = '0;
      osc_hz = OSC_RESET_HZ;
      slow_hz = SLOW_RESET_HZ;
      fast_hz = FAST_RESET_HZ;
      divisor_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_CLOCK_SOURCE: src_code = cfg_data_i[SRC_BITS-1:0];
          CFG_OSC_CLOCK:    osc_hz = cfg_data_i;
          CFG_SLOW_CLOCK:   slow_hz = cfg_data_i;
          CFG_FAST_CLOCK:   fast_hz = cfg_data_i;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        divisor_q.push_back(predict_divisor(req_i.baud_rate, req_i.on_fast_bus,
                                            req_i.oversample_by_8));
      end
      if (res_i.valid && res_i.ready) begin
        if (divisor_q.size() == 0) begin
          $error("result beat arrived with no request outstanding");
          fails++;
        end else begin
          want = divisor_q.pop_front();
          fails += check_field("divisor_word", want.divisor_word, res_i.divisor_word);
          fails += check_field("mantissa", 16'(want.mantissa), 16'(res_i.mantissa));
          fails += check_field("fraction", 16'(want.fraction), 16'(res_i.fraction));
          fails += check_field("out_of_range", 16'(want.out_of_range),
                               16'(res_i.out_of_range));
        end
      end
      fail_count_o <= fails;
      pending_o <= divisor_q.size();
    end
  end

endmodule

>>> tb/uart_baud_divisor_calc_test.sv
// Top of the UART baud divisor calculator test: clock, reset, request and result
// traffic, clock register settings and the verdict. Depends on ubdc_pkg, the channel
// interfaces, uart_baud_divisor_calc and ubdc_divisor_checker.
module uart_baud_divisor_calc_test;
  import ubdc_pkg::*;

  localparam int unsigned STD_RATES [8] = '{1200, 9600, 19200, 38400, 57600, 115200,
                                            921600, 4000000};

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CLOCK_BITS-1:0]   cfg_data_i;
  int                      fail_cnt;
  int                      pending_cnt;
  int                      sent_cnt;
  int                      setting_cnt;
  logic [SRC_BITS-1:0]     cur_src;
  logic [CLOCK_BITS-1:0]   cur_osc;
  logic [CLOCK_BITS-1:0]   cur_slow;
  logic [CLOCK_BITS-1:0]   cur_fast;
  logic                    calm;

  ubdc_in_if  req_ch ();
  ubdc_out_if res_ch ();

  uart_baud_divisor_calc u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_ch),
    .out_o      (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  ubdc_divisor_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .res_i        (res_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_cnt),
    .pending_o    (pending_cnt)
  );

  assign calm = (sent_cnt >= 1000) && (sent_cnt < 1300);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2000000;
    $display("uart_baud_divisor_calc_test: FAIL");
    $finish;
  end

  // Result side: random stalls, one long hold-off while requests keep coming,
  // and no stalls during the calm stretch.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent_cnt >= 400) begin
        hold_done = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (calm) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= 6);
      end
    end
  end

  task automatic send_req(logic [BAUD_BITS-1:0] baud, logic fast, logic by8);
    while (!calm && $urandom_range(0, 99) < 6) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.baud_rate <= baud;
    req_ch.on_fast_bus <= fast;
    req_ch.oversample_by_8 <= by8;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CLOCK_BITS-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [CLOCK_BITS-1:0] src_word, logic [CLOCK_BITS-1:0] osc,
                               logic [CLOCK_BITS-1:0] slow, logic [CLOCK_BITS-1:0] fast);
    settle();
    write_reg(CFG_CLOCK_SOURCE, src_word);
    write_reg(CFG_OSC_CLOCK, osc);
    write_reg(CFG_SLOW_CLOCK, slow);
    write_reg(CFG_FAST_CLOCK, fast);
    cfg_we_i <= 1'b0;
    cur_src = src_word[SRC_BITS-1:0];
    cur_osc = osc;
    cur_slow = slow;
    cur_fast = fast;
    setting_cnt++;
  endtask

  // Baud rates are biased toward the saturation edge, rounding ties and common rates.
  function automatic logic [BAUD_BITS-1:0] pick_baud(logic fast);
    logic [63:0] kernel_hz;
    logic [63:0] b;
    kernel_hz = (cur_src != '0) ? (fast ? 64'(cur_fast) : 64'(cur_slow)) : 64'(cur_osc);
    case ($urandom_range(0, 9))
      0, 1: b = 64'($urandom_range(0, 24'hFFFFFF));
      2: b = 64'($urandom_range(1, 600));
      3: b = 64'(STD_RATES[$urandom_range(0, 7)]);
      4: b = (64'd2 * kernel_hz) / (64'($urandom_range(0, 2047)) * 64'd2 + 64'd1);
      5: b = kernel_hz / 64'($urandom_range(1, 70000)) + 64'($urandom_range(0, 2));
      6: b = kernel_hz / ($urandom_range(0, 1) ? 64'd65536 : 64'd32768)
             + 64'($urandom_range(0, 4));
      7: b = ($urandom_range(0, 7) == 0) ? 64'd0 : 64'($urandom_range(1, 1000000));
      default: b = 64'($urandom_range(300, 4000000));
    endcase
    if (b > 64'h00FF_FFFF) begin
      b = 64'h00FF_FFFF;
    end
    return b[BAUD_BITS-1:0];
  endfunction

  task automatic run_random(int count);
    logic fast;
    repeat (count) begin
      fast = 1'($urandom_range(0, 1));
      send_req(pick_baud(fast), fast, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    sent_cnt = 0;
    setting_cnt = 1;
    cur_src = '0;
    cur_osc = OSC_RESET_HZ;
    cur_slow = SLOW_RESET_HZ;
    cur_fast = FAST_RESET_HZ;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CLOCK_SOURCE;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.baud_rate = '0;
    req_ch.on_fast_bus = 1'b0;
    req_ch.oversample_by_8 = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);

    // Reset clocks: zero baud, the saturation edge in both modes, ties, the field ends.
    send_req(24'd0, 1'b0, 1'b0);
    send_req(24'd0, 1'b1, 1'b1);
    send_req(24'd1, 1'b0, 1'b0);
    send_req(24'd1, 1'b1, 1'b1);
    send_req(24'hFFFFFF, 1'b0, 1'b0);
    send_req(24'hFFFFFF, 1'b1, 1'b1);
    send_req(24'd244, 1'b0, 1'b0);
    send_req(24'd245, 1'b0, 1'b0);
    send_req(24'd488, 1'b0, 1'b1);
    send_req(24'd489, 1'b1, 1'b1);
    send_req(24'd9600, 1'b0, 1'b0);
    send_req(24'd115200, 1'b1, 1'b1);
    send_req(24'd6400000, 1'b0, 1'b0);
    send_req(24'd6400000, 1'b0, 1'b1);
    send_req(24'd256000, 1'b1, 1'b0);
    send_req(24'd16000000, 1'b0, 1'b1);
    send_req(24'hAAAAAA, 1'b1, 1'b0);
    send_req(24'h555555, 1'b0, 1'b1);
    run_random(230);

    apply_setting(28'd3, 28'd1, 28'd168000000, 28'd1);
    run_random(230);
    apply_setting(28'd1, 28'd0, 28'd42000000, 28'd84000000);
    run_random(230);
    // Upper data bits set with a zero source code, so the oscillator applies.
    apply_setting(28'hFFFFFFC, 28'd168000000, 28'd1, 28'd168000000);
    run_random(230);
    apply_setting(28'd2, 28'($urandom_range(1, 168000000)), 28'd0, 28'hFFFFFFF);
    run_random(230);
    apply_setting(28'd0, 28'd0, 28'd1, 28'd1);
    run_random(100);
    apply_setting(28'($urandom_range(0, 3)), 28'($urandom_range(1, 168000000)),
                  28'($urandom_range(1, 168000000)), 28'($urandom_range(1, 168000000)));
    run_random(230);
    apply_setting(28'($urandom_range(1, 3)), 28'($urandom_range(1, 168000000)),
                  28'($urandom_range(1, 168000000)), 28'($urandom_range(1, 168000000)));
    run_random(230);
    apply_setting(28'd0, OSC_RESET_HZ, SLOW_RESET_HZ, FAST_RESET_HZ);
    run_random(100);

    settle();
    $display("Run covered %0d requests under %0d clock settings, both buses and both",
             sent_cnt, setting_cnt);
    $display("oversampling modes, with saturation, rounding ties and zero clocks.");
    if (fail_cnt == 0) begin
      $display("uart_baud_divisor_calc_test: PASS");
    end else begin
      $display("uart_baud_divisor_calc_test: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ubdc_pkg.sv
rtl/ubdc_in_if.sv
rtl/ubdc_out_if.sv
rtl/ubdc_head.sv
rtl/ubdc_cell.sv
rtl/ubdc_tail.sv
rtl/uart_baud_divisor_calc.sv
tb/ubdc_divisor_checker.sv
tb/uart_baud_divisor_calc_test.sv
